@@ sv/hsjf_pkg.sv @@
// Shared types and constants for the height step and jump filter.
package hsjf_pkg;

   localparam int unsigned RANGE_W = 16;
   localparam int unsigned TIME_W  = 32;
   localparam int unsigned DEV_W   = 32;
   localparam int unsigned DESK_W  = 12;
   localparam int unsigned THR_W   = 12;
   localparam int unsigned JUMP_W  = 10;
   localparam int unsigned PER_W   = 8;
   localparam int unsigned CSR_IDX_W  = 2;
   localparam int unsigned CSR_DATA_W = 12;

   localparam logic [CSR_IDX_W-1:0] CSR_DESK_HEIGHT    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_STEP_THRESHOLD = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_JUMP_LIMIT     = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_REF_PERIOD     = 2'd3;

   localparam logic [DESK_W-1:0] DESK_HEIGHT_RST    = 12'd750;
   localparam logic [THR_W-1:0]  STEP_THRESHOLD_RST = 12'd600;
   localparam logic [JUMP_W-1:0] JUMP_LIMIT_RST     = 10'd60;
   localparam logic [PER_W-1:0]  REF_PERIOD_RST     = 8'd8;

   typedef struct packed {
      logic [DESK_W-1:0] desk_height_mm;
      logic [THR_W-1:0]  step_threshold_mm;
      logic [JUMP_W-1:0] jump_limit_mm;
      logic [PER_W-1:0]  reference_period;
   } cfg_type;

   typedef struct packed {
      logic [RANGE_W-1:0] height_mm;
      logic               held;
      logic               over_desk;
   } res_type;

endpackage

@@ sv/hsjf_csr.sv @@
// Configuration registers of the height step and jump filter.
module hsjf_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_wr_en,
   input  logic [hsjf_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [hsjf_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output hsjf_pkg::cfg_type                cfg
);
   import hsjf_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_DESK_HEIGHT:    cfg_in.desk_height_mm    = csr_wdata[DESK_W-1:0];
            CSR_STEP_THRESHOLD: cfg_in.step_threshold_mm = csr_wdata[THR_W-1:0];
            CSR_JUMP_LIMIT:     cfg_in.jump_limit_mm     = csr_wdata[JUMP_W-1:0];
            CSR_REF_PERIOD:     cfg_in.reference_period  = csr_wdata[PER_W-1:0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.desk_height_mm    <= DESK_HEIGHT_RST;
         cfg_ff.step_threshold_mm <= STEP_THRESHOLD_RST;
         cfg_ff.jump_limit_mm     <= JUMP_LIMIT_RST;
         cfg_ff.reference_period  <= REF_PERIOD_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

@@ sv/hsjf_datapath.sv @@
// Filter state and the per-sample step, saturation and jump decision.
module hsjf_datapath (
   input  logic                           clock,
   input  logic                           reset,
   input  hsjf_pkg::cfg_type              cfg,
   input  logic                           fire,
   input  logic [hsjf_pkg::RANGE_W-1:0]   range_mm,
   output hsjf_pkg::res_type              res
);
   import hsjf_pkg::*;

   logic [RANGE_W-1:0] ref_range_ff, ref_range_in;
   logic               desk_flag_ff, desk_flag_in;
   logic [PER_W-1:0]   count_ff, count_in;
   logic [RANGE_W-1:0] acc_height_ff, acc_height_in;

   logic [RANGE_W:0]   range_x, ref_x, thr_x, desk_x, lim_x;
   logic [RANGE_W:0]   cand_sum, acc_x, cand_x;
   logic [RANGE_W-1:0] cand;
   logic               reject;
   logic [PER_W:0]     count_next;
   logic               ref_load;

   always_comb begin
      range_x = {1'b0, range_mm};
      ref_x   = {1'b0, ref_range_ff};
      thr_x   = (RANGE_W+1)'(cfg.step_threshold_mm);
      desk_x  = (RANGE_W+1)'(cfg.desk_height_mm);
      lim_x   = (RANGE_W+1)'(cfg.jump_limit_mm);

      // Compare in a 17-bit unsigned space so that no signed difference is needed.
      desk_flag_in = desk_flag_ff;
      if (range_x + thr_x < ref_x) begin
         desk_flag_in = 1'b1;
      end else if (range_x > ref_x + thr_x) begin
         desk_flag_in = 1'b0;
      end

      cand_sum = range_x + desk_x;
      if (!desk_flag_in) begin
         cand = range_mm;
      end else if (cand_sum[RANGE_W]) begin
         cand = {RANGE_W{1'b1}};
      end else begin
         cand = cand_sum[RANGE_W-1:0];
      end

      cand_x = {1'b0, cand};
      acc_x  = {1'b0, acc_height_ff};
      reject = (cand_x > acc_x + lim_x) || (acc_x > cand_x + lim_x);

      res.held      = reject;
      res.over_desk = desk_flag_in;
      res.height_mm = reject ? acc_height_ff : cand;
      acc_height_in = reject ? acc_height_ff : cand;

      // A period of zero behaves like one: every sample reloads the reference.
      count_next = {1'b0, count_ff} + (PER_W+1)'(1);
      ref_load   = count_next >= {1'b0, cfg.reference_period};
      count_in   = ref_load ? '0 : count_next[PER_W-1:0];
      ref_range_in = ref_load ? range_mm : ref_range_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ref_range_ff  <= '0;
         desk_flag_ff  <= 1'b0;
         count_ff      <= '0;
         acc_height_ff <= '0;
      end else if (fire) begin
         ref_range_ff  <= ref_range_in;
         desk_flag_ff  <= desk_flag_in;
         count_ff      <= count_in;
         acc_height_ff <= acc_height_in;
      end
   end

endmodule

@@ sv/height_step_and_jump_filter_top.sv @@
// Height step and jump filter: input register, filter step and result register.
// The result register takes the beat from the input register whenever it is empty or its result is taken.
// Throughput: one sample per cycle while results are taken; the filter state updates as each beat fires.
// While a result waits, the input register keeps its beat and a full stage stalls the input.
// Reset (synchronous, active high) empties both stages, clears the filter state
// and loads the register defaults: desk 750, threshold 600, jump 60, period 8.
module height_step_and_jump_filter_top (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [hsjf_pkg::RANGE_W-1:0]      req_range_mm,
   input  logic [hsjf_pkg::TIME_W-1:0]       req_sample_time,
   input  logic [hsjf_pkg::DEV_W-1:0]        req_deviation_word,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [hsjf_pkg::RANGE_W-1:0]      rsp_height_mm,
   output logic [hsjf_pkg::TIME_W-1:0]       rsp_out_time,
   output logic [hsjf_pkg::DEV_W-1:0]        rsp_out_deviation,
   output logic                              rsp_held,
   output logic                              rsp_over_desk,
   input  logic                              csr_wr_en,
   input  logic [hsjf_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [hsjf_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import hsjf_pkg::*;

   cfg_type cfg;
   res_type res;

   logic               in_vld_ff, in_vld_in;
   logic [RANGE_W-1:0] in_range_ff;
   logic [TIME_W-1:0]  in_time_ff;
   logic [DEV_W-1:0]   in_dev_ff;

   logic               out_vld_ff, out_vld_in;
   res_type            out_res_ff;
   logic [TIME_W-1:0]  out_time_ff;
   logic [DEV_W-1:0]   out_dev_ff;

   logic advance;
   logic req_beat;
   logic fire;

   hsjf_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   hsjf_datapath u_datapath (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .fire     (fire),
      .range_mm (in_range_ff),
      .res      (res)
   );

   assign advance   = !out_vld_ff || rsp_ready;
   assign req_ready = !in_vld_ff || advance;
   assign req_beat  = req_valid && req_ready;
   assign fire      = in_vld_ff && advance;

   always_comb begin
      if (req_beat) begin
         in_vld_in = 1'b1;
      end else if (advance) begin
         in_vld_in = 1'b0;
      end else begin
         in_vld_in = in_vld_ff;
      end
      out_vld_in = advance ? in_vld_ff : out_vld_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         in_vld_ff  <= in_vld_in;
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_beat) begin
         in_range_ff <= req_range_mm;
         in_time_ff  <= req_sample_time;
         in_dev_ff   <= req_deviation_word;
      end
      if (fire) begin
         out_res_ff  <= res;
         out_time_ff <= in_time_ff;
         out_dev_ff  <= in_dev_ff;
      end
   end

   assign rsp_valid         = out_vld_ff;
   assign rsp_height_mm     = out_res_ff.height_mm;
   assign rsp_held          = out_res_ff.held;
   assign rsp_over_desk     = out_res_ff.over_desk;
   assign rsp_out_time      = out_time_ff;
   assign rsp_out_deviation = out_dev_ff;

endmodule

@@ sv/hsjf_checker.sv @@
// Port-level checks for the height step and jump filter, bound to the top level.
module hsjf_checker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              rsp_valid,
   input  logic                              rsp_ready,
   input  logic [hsjf_pkg::RANGE_W-1:0]      rsp_height_mm,
   input  logic [hsjf_pkg::TIME_W-1:0]       rsp_out_time,
   input  logic                              rsp_held
);
   import hsjf_pkg::*;

   logic [RANGE_W-1:0] last_height_ff, last_height_in;

   // The height of the last delivered beat is the last accepted height.
   assign last_height_in = (rsp_valid && rsp_ready) ? rsp_height_mm : last_height_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         last_height_ff <= '0;
      end else begin
         last_height_ff <= last_height_in;
      end
   end

   a_idle_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result offered straight after reset");

   a_valid_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result beat withdrawn before it was taken");

   a_payload_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_height_mm) && $stable(rsp_out_time))
      else $error("result payload changed while stalled");

   a_held_repeats: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_held |-> rsp_height_mm == last_height_ff)
      else $error("rejected sample did not repeat the last accepted height");

endmodule

bind height_step_and_jump_filter_top hsjf_checker u_hsjf_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_valid),
   .rsp_ready     (rsp_ready),
   .rsp_height_mm (rsp_height_mm),
   .rsp_out_time  (rsp_out_time),
   .rsp_held      (rsp_held)
);

@@ verif/height_step_and_jump_filter_top_test.sv @@
// Self-checking testbench for the height step and jump filter top level.
`timescale 1ns / 100ps

class height_filter_scoreboard;
   typedef struct {
      hsjf_pkg::res_type                filt;
      logic [hsjf_pkg::TIME_W-1:0]      stamp;
      logic [hsjf_pkg::DEV_W-1:0]       dev;
   } height_beat_type;

   logic [hsjf_pkg::DESK_W-1:0]  desk_offset;
   logic [hsjf_pkg::THR_W-1:0]   step_threshold;
   logic [hsjf_pkg::JUMP_W-1:0]  jump_limit;
   logic [hsjf_pkg::PER_W-1:0]   ref_period;

   logic [hsjf_pkg::RANGE_W-1:0] ref_range;
   logic                         on_desk;
   logic [hsjf_pkg::PER_W-1:0]   since_update;
   logic [hsjf_pkg::RANGE_W-1:0] last_height;

   height_beat_type expected_heights[$];
   int errors;

   function new();
      desk_offset    = hsjf_pkg::DESK_HEIGHT_RST;
      step_threshold = hsjf_pkg::STEP_THRESHOLD_RST;
      jump_limit     = hsjf_pkg::JUMP_LIMIT_RST;
      ref_period     = hsjf_pkg::REF_PERIOD_RST;
      ref_range      = '0;
      on_desk        = 1'b0;
      since_update   = '0;
      last_height    = '0;
      errors         = 0;
   endfunction

   function void write_register(logic [hsjf_pkg::CSR_IDX_W-1:0] index,
                                logic [hsjf_pkg::CSR_DATA_W-1:0] value);
      case (index)
         hsjf_pkg::CSR_DESK_HEIGHT:    desk_offset = value[hsjf_pkg::DESK_W-1:0];
         hsjf_pkg::CSR_STEP_THRESHOLD: step_threshold = value[hsjf_pkg::THR_W-1:0];
         hsjf_pkg::CSR_JUMP_LIMIT:     jump_limit = value[hsjf_pkg::JUMP_W-1:0];
         hsjf_pkg::CSR_REF_PERIOD:     ref_period = value[hsjf_pkg::PER_W-1:0];
         default: ;
      endcase
   endfunction

   // Works out the filtered height for one accepted sample beat.
   function void note_sample(logic [hsjf_pkg::RANGE_W-1:0] range_mm,
                             logic [hsjf_pkg::TIME_W-1:0] stamp,
                             logic [hsjf_pkg::DEV_W-1:0] dev);
      int diff;
      int thr;
      int cand;
      int change;
      int unsigned next_count;
      height_beat_type beat;
      diff = int'(range_mm) - int'(ref_range);
      thr  = int'(step_threshold);
      if (diff < -thr) begin
         on_desk = 1'b1;
      end else if (diff > thr) begin
         on_desk = 1'b0;
      end
      cand = int'(range_mm);
      if (on_desk) begin
         cand = int'(range_mm) + int'(desk_offset);
         if (cand > 65535) begin
            cand = 65535;
         end
      end
      change = cand - int'(last_height);
      beat.filt.held = (change > int'(jump_limit)) || (change < -int'(jump_limit));
      if (!beat.filt.held) begin
         last_height = cand[hsjf_pkg::RANGE_W-1:0];
      end
      beat.filt.height_mm = last_height;
      beat.filt.over_desk = on_desk;
      // A period of zero behaves like one, since the count always reaches it.
      next_count = int'(since_update) + 1;
      if (next_count >= int'(ref_period)) begin
         since_update = '0;
         ref_range    = range_mm;
      end else begin
         since_update = next_count[hsjf_pkg::PER_W-1:0];
      end
      beat.stamp = stamp;
      beat.dev   = dev;
      expected_heights.push_back(beat);
   endfunction

   function void compare_field(string field, longint unsigned want, longint unsigned got);
      if (want != got) begin
         errors++;
         $display("%0t: mismatch on %s, expected %0d, actual %0d", $time, field, want, got);
      end
   endfunction

   function void check_result(logic [hsjf_pkg::RANGE_W-1:0] height_mm,
                              logic [hsjf_pkg::TIME_W-1:0] stamp,
                              logic [hsjf_pkg::DEV_W-1:0] dev,
                              logic held, logic over_desk);
      height_beat_type beat;
      if (expected_heights.size() == 0) begin
         errors++;
         $display("%0t: unexpected result beat, height %0d", $time, height_mm);
         return;
      end
      beat = expected_heights.pop_front();
      compare_field("height_mm", beat.filt.height_mm, height_mm);
      compare_field("out_time", beat.stamp, stamp);
      compare_field("out_deviation", beat.dev, dev);
      compare_field("held", beat.filt.held, held);
      compare_field("over_desk", beat.filt.over_desk, over_desk);
   endfunction
endclass

module height_step_and_jump_filter_top_test;
   import hsjf_pkg::*;

   localparam int CYCLE_LIMIT = 300000;
   localparam int ITEMS_PER_SETTING = 150;
   localparam int DIRECTED_RANGES[12] = '{0, 600, 0, 1000, 399, 1000, 2023, 3047, 1000,
                                          65535, 64000, 0};

   typedef enum {EP_WALK, EP_CLIMB, EP_NOISE, EP_SHIFT} episode_kind_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic [RANGE_W-1:0]    req_range_mm = '0;
   logic [TIME_W-1:0]     req_sample_time = '0;
   logic [DEV_W-1:0]      req_deviation_word = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [RANGE_W-1:0]    rsp_height_mm;
   logic [TIME_W-1:0]     rsp_out_time;
   logic [DEV_W-1:0]      rsp_out_deviation;
   logic                  rsp_held;
   logic                  rsp_over_desk;
   logic                  csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   height_filter_scoreboard sb;
   int cycle_count = 0;
   int sender_idle_pct = 0;
   int receiver_idle_pct = 0;

   // Shape of the simulated flight: true floor height, desk offset and episode.
   int floor_mm = 0;
   logic desk_on = 1'b0;
   int desk_depth = 0;
   int episode_left = 0;
   int climb_target = 0;
   episode_kind_type episode_kind = EP_WALK;

   height_step_and_jump_filter_top dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_range_mm       (req_range_mm),
      .req_sample_time    (req_sample_time),
      .req_deviation_word (req_deviation_word),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_height_mm      (rsp_height_mm),
      .rsp_out_time       (rsp_out_time),
      .rsp_out_deviation  (rsp_out_deviation),
      .rsp_held           (rsp_held),
      .rsp_over_desk      (rsp_over_desk),
      .csr_wr_en          (csr_wr_en),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   always #2 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= receiver_idle_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         sb.check_result(rsp_height_mm, rsp_out_time, rsp_out_deviation, rsp_held,
                         rsp_over_desk);
      end
   end

   function automatic int clamp_range(int value);
      if (value < 0) return 0;
      if (value > 65535) return 65535;
      return value;
   endfunction

   function automatic logic [TIME_W-1:0] pick_word();
      case ($urandom_range(9))
         0: return '0;
         1: return '1;
         default: return $urandom;
      endcase
   endfunction

   // Mostly plausible flight: slow drift, desk edges and climbs, with noise and
   // sudden jumps mixed in.
   function automatic logic [RANGE_W-1:0] pick_range();
      int step;
      int delta;
      if (episode_left == 0) begin
         episode_left = $urandom_range(40, 5);
         case ($urandom_range(9))
            0, 1, 2, 3, 4: episode_kind = EP_WALK;
            5, 6: begin
               episode_kind = EP_CLIMB;
               episode_left = $urandom_range(90, 30);
               if ($urandom_range(1) == 0) begin
                  climb_target = ($urandom_range(1) == 0) ? 65535 : 0;
               end else begin
                  climb_target = $urandom_range(65535);
               end
            end
            7, 8: episode_kind = EP_NOISE;
            default: begin
               episode_kind = EP_SHIFT;
               episode_left = 1;
            end
         endcase
      end
      episode_left--;
      case (episode_kind)
         EP_WALK: begin
            step = int'(sb.jump_limit) / 2 + 1;
            floor_mm = clamp_range(floor_mm + int'($urandom_range(2 * step)) - step);
            if ($urandom_range(9) == 0) begin
               desk_on = !desk_on;
               desk_depth = ($urandom_range(3) != 0) ? int'(sb.desk_offset)
                                                     : int'($urandom_range(4095));
            end
         end
         EP_CLIMB: begin
            delta = int'($urandom_range(int'(sb.jump_limit)));
            if (climb_target > floor_mm) begin
               floor_mm = (floor_mm + delta > climb_target) ? climb_target : floor_mm + delta;
            end else begin
               floor_mm = (floor_mm - delta < climb_target) ? climb_target : floor_mm - delta;
            end
         end
         EP_NOISE: begin
            case ($urandom_range(5))
               0: return '0;
               1: return '1;
               default: return 16'($urandom_range(65535));
            endcase
         end
         default: floor_mm = $urandom_range(65535);
      endcase
      return 16'(clamp_range(floor_mm - (desk_on ? desk_depth : 0)));
   endfunction

   task automatic write_csr(input logic [CSR_IDX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_wr_en = 1'b1;
      csr_index = index;
      csr_wdata = value;
      sb.write_register(index, value);
      @(negedge clock);
      csr_wr_en = 1'b0;
   endtask

   task automatic send_sample(input logic [RANGE_W-1:0] range_mm,
                              input logic [TIME_W-1:0] stamp,
                              input logic [DEV_W-1:0] dev);
      @(negedge clock);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_range_mm       = range_mm;
      req_sample_time    = stamp;
      req_deviation_word = dev;
      req_valid          = 1'b1;
      do begin
         @(posedge clock);
      end while (!req_ready);
      sb.note_sample(range_mm, stamp, dev);
   endtask

   // Holds the sender off until every outstanding beat has come back.
   task automatic wait_drained();
      @(negedge clock);
      req_valid = 1'b0;
      while (sb.expected_heights.size() != 0) begin
         @(posedge clock);
      end
      repeat (4) @(posedge clock);
   endtask

   task automatic apply_setting(input int seg);
      logic [CSR_DATA_W-1:0] desk;
      logic [CSR_DATA_W-1:0] thr;
      logic [CSR_DATA_W-1:0] jump;
      logic [CSR_DATA_W-1:0] period;
      if (seg == 0) begin
         desk = 12'd4095;
         thr = 12'd4095;
         jump = 12'd1023;
         period = 12'd255;
      end else if (seg == 4) begin
         desk = '0;
         thr = '0;
         jump = '0;
         period = '0;
      end else if (seg == 8) begin
         desk = 12'(DESK_HEIGHT_RST);
         thr = 12'(STEP_THRESHOLD_RST);
         jump = 12'(JUMP_LIMIT_RST);
         period = 12'(REF_PERIOD_RST);
      end else begin
         desk = 12'($urandom_range(4095));
         thr = ($urandom_range(1) == 0) ? 12'($urandom_range(4095))
                                        : 12'($urandom_range(1200));
         jump = ($urandom_range(3) == 0) ? 12'($urandom_range(4095))
                                         : 12'($urandom_range(1023, 8));
         period = ($urandom_range(3) == 0) ? 12'($urandom_range(4095))
                                           : 12'($urandom_range(16, 1));
      end
      write_csr(CSR_DESK_HEIGHT, desk);
      write_csr(CSR_STEP_THRESHOLD, thr);
      write_csr(CSR_JUMP_LIMIT, jump);
      write_csr(CSR_REF_PERIOD, period);
   endtask

   initial begin
      logic [TIME_W-1:0] stamp;
      sb = new();
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      sender_idle_pct = 22;
      receiver_idle_pct = 73;

      // With a period of one the reference is always the previous sample, which
      // makes threshold and jump edges easy to place.
      write_csr(CSR_DESK_HEIGHT, 12'd750);
      write_csr(CSR_STEP_THRESHOLD, 12'd600);
      write_csr(CSR_JUMP_LIMIT, 12'd1023);
      write_csr(CSR_REF_PERIOD, 12'd1);
      for (int i = 0; i < 12; i++) begin
         stamp = (i == 0) ? '0 : (i == 1) ? '1 : $urandom;
         send_sample(16'(DIRECTED_RANGES[i]), stamp, stamp ^ $urandom);
      end

      // Count up under a long period, then cut the period below the count.
      wait_drained();
      write_csr(CSR_REF_PERIOD, 12'd255);
      for (int i = 1; i <= 5; i++) begin
         send_sample(16'(100 * i), $urandom, $urandom);
      end
      wait_drained();
      write_csr(CSR_REF_PERIOD, 12'd2);
      send_sample(16'd510, $urandom, $urandom);
      send_sample(16'd520, $urandom, $urandom);
      wait_drained();
      write_csr(CSR_REF_PERIOD, 12'd0);
      send_sample(16'd530, $urandom, $urandom);
      send_sample(16'd540, $urandom, $urandom);
      floor_mm = 540;

      for (int seg = 0; seg < 9; seg++) begin
         sender_idle_pct = (seg < 3) ? 22 : (seg < 6) ? 73 : 0;
         receiver_idle_pct = (seg < 3) ? 73 : (seg < 6) ? 22 : 0;
         wait_drained();
         apply_setting(seg);
         repeat (ITEMS_PER_SETTING) begin
            send_sample(pick_range(), pick_word(), pick_word());
         end
      end

      @(negedge clock);
      req_valid = 1'b0;
      while (sb.expected_heights.size() != 0) begin
         @(posedge clock);
      end
      repeat (8) @(posedge clock);
      if (sb.errors == 0 && sb.expected_heights.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end
endmodule

@@ filelist.f @@
sv/hsjf_pkg.sv
sv/hsjf_csr.sv
sv/hsjf_datapath.sv
sv/height_step_and_jump_filter_top.sv
sv/hsjf_checker.sv
verif/height_step_and_jump_filter_top_test.sv
